[hw/rtl/iss_pkg.sv]
package iss_pkg;

    localparam int KIND_BITS   = 3;
    localparam int VALUE_BITS  = 32;
    localparam int INDEX_BITS  = 8;
    localparam int POS_BITS    = 8;
    localparam int COUNT_BITS  = 9;
    localparam int STATUS_BITS = 2;

    localparam logic [KIND_BITS-1:0] KIND_PUSH   = 3'd0;
    localparam logic [KIND_BITS-1:0] KIND_POP    = 3'd1;
    localparam logic [KIND_BITS-1:0] KIND_TOP    = 3'd2;
    localparam logic [KIND_BITS-1:0] KIND_READ   = 3'd3;
    localparam logic [KIND_BITS-1:0] KIND_WRITE  = 3'd4;
    localparam logic [KIND_BITS-1:0] KIND_SEARCH = 3'd5;

    localparam logic [STATUS_BITS-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_BITS-1:0] STAT_OVERFLOW  = 2'd1;
    localparam logic [STATUS_BITS-1:0] STAT_UNDERFLOW = 2'd2;
    localparam logic [STATUS_BITS-1:0] STAT_RANGE     = 2'd3;

    typedef struct packed {
        logic [KIND_BITS-1:0]  kind;
        logic [VALUE_BITS-1:0] value;
        logic [INDEX_BITS-1:0] index;
    } t_req;

    typedef struct packed {
        logic [VALUE_BITS-1:0]  word;
        logic [POS_BITS-1:0]    position;
        logic                   found;
        logic [COUNT_BITS-1:0]  count;
        logic [STATUS_BITS-1:0] status;
    } t_rsp;

    // Result fields known before the memory read data returns.
    typedef struct packed {
        logic                   use_rdata;
        logic [POS_BITS-1:0]    position;
        logic                   found;
        logic [COUNT_BITS-1:0]  count;
        logic [STATUS_BITS-1:0] status;
    } t_meta;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } t_state;

endpackage

[hw/rtl/iss_stream_if.sv]
interface iss_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/indexed_search_stack.sv]
// Channel   Direction  Payload               Transaction
// i_req     in         iss_pkg::t_req        i_req.valid && i_req.ready
// o_rsp     out        iss_pkg::t_rsp        o_rsp.valid && o_rsp.ready
//
// Push, pop, top, read and write can follow back to back while o_rsp is not stalled;
// each result passes through r_p and then r_rsp before it appears on o_rsp.
// A search walks the single-port store one entry per cycle unless r_p holds a result.
// Reset (synchronous, active low) empties the stack; the store itself is not cleared.
// A stalled output holds one result and one more in flight before requests stall.
module indexed_search_stack #(
    parameter int DEPTH     = 256,
    parameter int WORD_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    iss_stream_if.sink   i_req,
    iss_stream_if.source o_rsp
);
    import iss_pkg::*;

    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WORD_BITS-1:0] r_mem [DEPTH];
    logic [WORD_BITS-1:0] r_rdata;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_p_valid;
    t_meta              r_p;
    logic               r_o_valid;
    t_rsp               r_rsp;
    logic [WORD_BITS-1:0] r_key;
    logic [CNT_W-1:0]   r_scan_addr;
    logic [AW-1:0]      r_cmp_addr;
    logic               r_cmp_pend;

    logic               acc, out_free, p_adv;
    logic               mem_we, mem_re;
    logic [AW-1:0]      mem_addr;
    logic [WORD_BITS-1:0] val;
    logic [CNT_W-1:0]   cnt_m1;
    logic               is_full, is_empty, idx_oor;
    logic               start_scan;
    t_meta              meta_acc, meta_scan;
    logic               scan_hit, scan_last, scan_done, scan_issue;

    assign val      = WORD_BITS'(i_req.data.value);
    assign cnt_m1   = r_count - CNT_W'(1);
    assign is_full  = (r_count == CNT_W'(DEPTH));
    assign is_empty = (r_count == '0);
    assign idx_oor  = ({CNT_W'(0), i_req.data.index} >= {8'd0, r_count});

    assign out_free = !r_o_valid || o_rsp.ready;
    assign p_adv    = r_p_valid && out_free;
    assign i_req.ready = (r_state == ST_IDLE) && (!r_p_valid || out_free);
    assign acc      = i_req.valid && i_req.ready;

    // Scan compares the word read last cycle while the next read is issued.
    assign scan_hit   = r_cmp_pend && (r_rdata == r_key);
    assign scan_last  = r_cmp_pend && (CNT_W'(r_cmp_addr) == cnt_m1);
    assign scan_done  = (r_state == ST_SCAN) && (scan_hit || scan_last);
    assign scan_issue = (r_state == ST_SCAN) && !scan_done && !r_p_valid
                        && (r_scan_addr < r_count);

    always_comb begin
        meta_scan           = '0;
        meta_scan.found     = scan_hit;
        meta_scan.position  = scan_hit ? POS_BITS'(r_cmp_addr) : '0;
        meta_scan.count     = COUNT_BITS'(r_count);
        meta_scan.status    = STAT_OK;
    end

    always_comb begin
        n_count    = r_count;
        n_state    = r_state;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_addr   = AW'(r_scan_addr);
        start_scan = 1'b0;
        meta_acc   = '0;
        if (r_state == ST_SCAN) begin
            mem_re = scan_issue;
            if (scan_done) begin
                n_state = ST_IDLE;
            end
        end else if (acc) begin
            case (i_req.data.kind)
                KIND_PUSH: begin
                    if (is_full) begin
                        meta_acc.status = STAT_OVERFLOW;
                    end else begin
                        mem_we   = 1'b1;
                        mem_addr = AW'(r_count);
                        n_count  = r_count + CNT_W'(1);
                    end
                end
                KIND_POP: begin
                    if (is_empty) begin
                        meta_acc.status = STAT_UNDERFLOW;
                    end else begin
                        n_count = cnt_m1;
                    end
                end
                KIND_TOP: begin
                    if (is_empty) begin
                        meta_acc.status = STAT_UNDERFLOW;
                    end else begin
                        mem_re             = 1'b1;
                        mem_addr           = AW'(cnt_m1);
                        meta_acc.use_rdata = 1'b1;
                    end
                end
                KIND_READ: begin
                    if (idx_oor) begin
                        meta_acc.status = STAT_RANGE;
                    end else begin
                        mem_re             = 1'b1;
                        mem_addr           = AW'(i_req.data.index);
                        meta_acc.use_rdata = 1'b1;
                    end
                end
                KIND_WRITE: begin
                    if (idx_oor) begin
                        meta_acc.status = STAT_RANGE;
                    end else begin
                        mem_we   = 1'b1;
                        mem_addr = AW'(i_req.data.index);
                    end
                end
                KIND_SEARCH: begin
                    if (!is_empty) begin
                        start_scan = 1'b1;
                        n_state    = ST_SCAN;
                    end
                end
                default: begin
                end
            endcase
            meta_acc.count = COUNT_BITS'(n_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= val;
        end else if (mem_re) begin
            r_rdata <= r_mem[mem_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_count    <= '0;
            r_p_valid  <= 1'b0;
            r_o_valid  <= 1'b0;
            r_cmp_pend <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_cmp_pend <= scan_issue;
            if ((acc && !start_scan) || scan_done) begin
                r_p_valid <= 1'b1;
            end else if (p_adv) begin
                r_p_valid <= 1'b0;
            end
            if (p_adv) begin
                r_o_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && !start_scan) begin
            r_p <= meta_acc;
        end else if (scan_done) begin
            r_p <= meta_scan;
        end
        if (start_scan) begin
            r_key       <= val;
            r_scan_addr <= '0;
        end else if (scan_issue) begin
            r_scan_addr <= r_scan_addr + CNT_W'(1);
        end
        if (scan_issue) begin
            r_cmp_addr <= AW'(r_scan_addr);
        end
        if (p_adv) begin
            r_rsp.word     <= r_p.use_rdata ? VALUE_BITS'(r_rdata) : '0;
            r_rsp.position <= r_p.position;
            r_rsp.found    <= r_p.found;
            r_rsp.count    <= r_p.count;
            r_rsp.status   <= r_p.status;
        end
    end

    assign o_rsp.valid = r_o_valid;
    assign o_rsp.data  = r_rsp;

    // The scan only reads the store while no result waits on the read data.
    a_scan_no_clobber: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_cmp_pend && r_p_valid))
        else $error("scan read data overlaps a pending result");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count beyond depth");

    a_scan_count_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |=> (r_count == $past(r_count)))
        else $error("entry count changed during a search");

    a_scan_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> !i_req.ready)
        else $error("request taken during a search");

endmodule
